// ===== design/glc_pkg.sv =====
// Shared constants and controller/datapath interface types for the glyph slot cache.
package glc_pkg;

  localparam int unsigned SlotCountDef  = 256;
  localparam int unsigned StampWidthDef = 32;
  localparam int unsigned CodeWidthDef  = 21;

  localparam int unsigned CharCodeW  = 21;
  localparam int unsigned SlotIndexW = 8;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } glc_cmd_t;

  typedef struct packed {
    logic last_addr;
  } glc_status_t;

endpackage

// ===== design/glc_ctrl.sv =====
// Controller state machine: sequences lookup scan, commit and result handoff.
module glc_ctrl
  import glc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  glc_status_t status_i,
  output glc_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.last_addr) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/glc_datapath.sv =====
// Datapath: tag and stamp memories, valid bits, hit search, LRU victim scan, use counter.
module glc_datapath
  import glc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = SlotCountDef,
  parameter int unsigned STAMP_WIDTH = StampWidthDef,
  parameter int unsigned CODE_WIDTH  = CodeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glc_cmd_t              cmd_i,
  output glc_status_t           status_o,
  input  logic [CharCodeW-1:0]  char_code_i,
  output logic [SlotIndexW-1:0] slot_index_o,
  output logic                  needs_render_o
);

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);

  logic [CODE_WIDTH-1:0]  tag_mem   [SLOT_COUNT];
  logic [STAMP_WIDTH-1:0] stamp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_q;

  logic [CODE_WIDTH-1:0]  code_q;
  logic [SlotW-1:0]       addr_q;
  logic                   rd_vld_q;
  logic [SlotW-1:0]       rd_idx_q;
  logic [CODE_WIDTH-1:0]  tag_rd_q;
  logic [STAMP_WIDTH-1:0] stamp_rd_q;
  logic                   slot_vld_rd_q;
  logic [SlotW-1:0]       best_slot_q;
  logic [STAMP_WIDTH-1:0] best_age_q;
  logic                   hit_q;
  logic [SlotW-1:0]       hit_slot_q;
  logic [STAMP_WIDTH-1:0] counter_q;
  logic [SlotIndexW-1:0]  slot_index_q;
  logic                   needs_render_q;

  logic [STAMP_WIDTH-1:0] stamp_eff;
  logic [STAMP_WIDTH-1:0] age;
  logic [STAMP_WIDTH-1:0] stamp_next;
  logic                   take_best;
  logic                   match;
  logic [SlotW-1:0]       commit_slot;

  // an unmapped slot reads back a zero stamp
  assign stamp_eff   = slot_vld_rd_q ? stamp_rd_q : '0;
  assign age         = counter_q - stamp_eff;
  assign take_best   = (rd_idx_q == SlotW'(1)) || (age > best_age_q);
  assign match       = slot_vld_rd_q && (tag_rd_q == code_q);
  assign commit_slot = hit_q ? hit_slot_q : best_slot_q;
  assign stamp_next  = counter_q + STAMP_WIDTH'(1);

  assign status_o.last_addr = (addr_q == SlotW'(SLOT_COUNT - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      tag_rd_q   <= tag_mem[addr_q];
      stamp_rd_q <= stamp_mem[addr_q];
    end
    if (cmd_i.commit) begin
      stamp_mem[commit_slot] <= stamp_next;
      if (!hit_q) begin
        tag_mem[commit_slot] <= code_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      counter_q <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        hit_q <= 1'b0;
      end else if (rd_vld_q && match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        valid_q[commit_slot] <= 1'b1;
        counter_q            <= stamp_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      code_q <= CODE_WIDTH'(char_code_i);
      addr_q <= SlotW'(1);
    end else if (cmd_i.scan) begin
      addr_q <= addr_q + SlotW'(1);
    end
    if (cmd_i.scan) begin
      rd_idx_q      <= addr_q;
      slot_vld_rd_q <= valid_q[addr_q];
    end
    if (rd_vld_q) begin
      if (take_best) begin
        best_slot_q <= rd_idx_q;
        best_age_q  <= age;
      end
      if (match && !hit_q) begin
        hit_slot_q <= rd_idx_q;
      end
    end
    if (cmd_i.commit) begin
      slot_index_q   <= SlotIndexW'(commit_slot);
      needs_render_q <= !hit_q;
    end
  end

  assign slot_index_o   = slot_index_q;
  assign needs_render_o = needs_render_q;

  a_commit_not_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> commit_slot != '0)
    else $error("slot 0 chosen at commit");

  a_hit_is_mapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && hit_q |-> valid_q[hit_slot_q])
    else $error("hit on unmapped slot");

  a_counter_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> counter_q == $past(stamp_next))
    else $error("use counter did not advance by one");

  a_scan_before_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !cmd_i.commit)
    else $error("commit while scan data still in flight");

endmodule

// ===== design/glyph_slot_lru_cache.sv =====
// Top level of the glyph atlas slot cache: controller plus datapath.
// Each transaction on the input passes through these steps in order: it is accepted,
// then one read per slot 1..SLOT_COUNT-1 is made from the single-port tag and
// stamp memories (hit search and least-recently-used victim search share that scan),
// the last read lands, and a commit writes tag, stamp and valid bit once the output
// register is free. The result sits in an output register, so the next character is
// accepted while the previous result still waits to be taken. Slot 0 is never
// assigned. Reset clears valid bits and the use counter at once; no clearing pass.
module glyph_slot_lru_cache
  import glc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = SlotCountDef,
  parameter int unsigned STAMP_WIDTH = StampWidthDef,
  parameter int unsigned CODE_WIDTH  = CodeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CharCodeW-1:0]  char_code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SlotIndexW-1:0] slot_index_o,
  output logic                  needs_render_o
);

  glc_cmd_t    cmd;
  glc_status_t status;

  glc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  glc_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .STAMP_WIDTH (STAMP_WIDTH),
    .CODE_WIDTH  (CODE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .char_code_i    (char_code_i),
    .slot_index_o   (slot_index_o),
    .needs_render_o (needs_render_o)
  );

endmodule
